/* hdl/srect_pkg.sv */
// shared constants and types for the segment/rectangle intersection core
package srect_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int TOL_BITS       = 8;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 8'd3;

    localparam int NUM_EDGES   = 4;
    localparam int EDGE_TOP    = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_BOTTOM = 2;
    localparam int EDGE_LEFT   = 3;

    // control bits that travel with each word
    typedef struct packed {
        logic vld;
        logic wnz;
        logic hnz;
    } t_ctl;

endpackage

/* hdl/srect_front.sv */
// front pipeline: edge geometry, products, numerators and magnitudes
module srect_front #(
    parameter int CW = srect_pkg::COORD_BITS_DEF,
    parameter int FW = srect_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [CW-1:0]          i_x1,
    input  logic signed [CW-1:0]          i_y1,
    input  logic signed [CW-1:0]          i_x2,
    input  logic signed [CW-1:0]          i_y2,
    input  logic signed [CW-1:0]          i_l,
    input  logic signed [CW-1:0]          i_t,
    input  logic        [CW-2:0]          i_w,
    input  logic        [CW-2:0]          i_h,
    output srect_pkg::t_ctl               o_ctl,
    output logic                          o_neg  [srect_pkg::NUM_EDGES],
    output logic        [2*CW+FW+2:0]     o_amag [srect_pkg::NUM_EDGES],
    output logic        [CW:0]            o_dmag [srect_pkg::NUM_EDGES],
    output logic signed [CW-1:0]          o_x1,
    output logic signed [CW-1:0]          o_y1,
    output logic signed [CW-1:0]          o_x2,
    output logic signed [CW-1:0]          o_y2,
    output logic signed [CW:0]            o_l,
    output logic signed [CW:0]            o_t,
    output logic signed [CW:0]            o_r,
    output logic signed [CW:0]            o_b
);
    import srect_pkg::*;

    localparam int EW = CW + 1;
    localparam int NW = 2 * CW + 3;
    localparam int PW = 2 * EW;

    // stage 1
    t_ctl                 r1_ctl;
    logic signed [CW-1:0] r1_x1, r1_y1, r1_x2, r1_y2;
    logic signed [EW-1:0] r1_l, r1_t, r1_r, r1_b, r1_dx, r1_dy;
    // stage 2
    t_ctl                 r2_ctl;
    logic signed [CW-1:0] r2_x1, r2_y1, r2_x2, r2_y2;
    logic signed [EW-1:0] r2_l, r2_t, r2_r, r2_b, r2_dx, r2_dy;
    logic signed [2*CW-1:0] r2_p12, r2_p21;
    logic signed [PW-1:0] r2_dxt, r2_dxb, r2_dyr, r2_dyl;
    // stage 3
    t_ctl                 r3_ctl;
    logic signed [CW-1:0] r3_x1, r3_y1, r3_x2, r3_y2;
    logic signed [EW-1:0] r3_l, r3_t, r3_r, r3_b;
    logic signed [NW-1:0] r3_num [NUM_EDGES];
    logic signed [EW-1:0] r3_den [NUM_EDGES];
    logic signed [NW-1:0] n3_cross;
    logic signed [NW-1:0] n3_num [NUM_EDGES];
    // stage 4
    t_ctl                 r4_ctl;
    logic                 r4_neg  [NUM_EDGES];
    logic [NW+FW-1:0]     r4_amag [NUM_EDGES];
    logic [EW-1:0]        r4_dmag [NUM_EDGES];
    logic signed [CW-1:0] r4_x1, r4_y1, r4_x2, r4_y2;
    logic signed [EW-1:0] r4_l, r4_t, r4_r, r4_b;
    logic [NW-1:0]        n4_mag  [NUM_EDGES];
    logic [EW-1:0]        n4_dmag [NUM_EDGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else begin
            r1_ctl <= '{vld: i_start, wnz: |i_w, hnz: |i_h};
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_comb begin
        n3_cross = NW'(r2_p12) - NW'(r2_p21);
        n3_num[EDGE_TOP]    = n3_cross + NW'(r2_dxt);
        n3_num[EDGE_RIGHT]  = NW'(r2_dyr) - n3_cross;
        n3_num[EDGE_BOTTOM] = n3_cross + NW'(r2_dxb);
        n3_num[EDGE_LEFT]   = NW'(r2_dyl) - n3_cross;
        for (int k = 0; k < NUM_EDGES; k++) begin
            n4_mag[k]  = r3_num[k][NW-1] ? NW'(-r3_num[k]) : NW'(r3_num[k]);
            n4_dmag[k] = r3_den[k][EW-1] ? EW'(-r3_den[k]) : EW'(r3_den[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x1 <= i_x1;
        r1_y1 <= i_y1;
        r1_x2 <= i_x2;
        r1_y2 <= i_y2;
        r1_l  <= EW'(i_l);
        r1_t  <= EW'(i_t);
        r1_r  <= EW'(i_l) + EW'(i_w);
        r1_b  <= EW'(i_t) + EW'(i_h);
        r1_dx <= EW'(i_x2) - EW'(i_x1);
        r1_dy <= EW'(i_y2) - EW'(i_y1);

        r2_x1 <= r1_x1;
        r2_y1 <= r1_y1;
        r2_x2 <= r1_x2;
        r2_y2 <= r1_y2;
        r2_l  <= r1_l;
        r2_t  <= r1_t;
        r2_r  <= r1_r;
        r2_b  <= r1_b;
        r2_dx <= r1_dx;
        r2_dy <= r1_dy;
        r2_p12 <= r1_x1 * r1_y2;
        r2_p21 <= r1_x2 * r1_y1;
        r2_dxt <= r1_dx * r1_t;
        r2_dxb <= r1_dx * r1_b;
        r2_dyr <= r1_dy * r1_r;
        r2_dyl <= r1_dy * r1_l;

        r3_x1 <= r2_x1;
        r3_y1 <= r2_y1;
        r3_x2 <= r2_x2;
        r3_y2 <= r2_y2;
        r3_l  <= r2_l;
        r3_t  <= r2_t;
        r3_r  <= r2_r;
        r3_b  <= r2_b;
        for (int k = 0; k < NUM_EDGES; k++) begin
            r3_num[k] <= n3_num[k];
        end
        r3_den[EDGE_TOP]    <= r2_dy;
        r3_den[EDGE_RIGHT]  <= r2_dx;
        r3_den[EDGE_BOTTOM] <= r2_dy;
        r3_den[EDGE_LEFT]   <= r2_dx;

        r4_x1 <= r3_x1;
        r4_y1 <= r3_y1;
        r4_x2 <= r3_x2;
        r4_y2 <= r3_y2;
        r4_l  <= r3_l;
        r4_t  <= r3_t;
        r4_r  <= r3_r;
        r4_b  <= r3_b;
        for (int k = 0; k < NUM_EDGES; k++) begin
            r4_neg[k]  <= r3_num[k][NW-1] ^ r3_den[k][EW-1];
            r4_amag[k] <= {n4_mag[k], {FW{1'b0}}};
            r4_dmag[k] <= n4_dmag[k];
        end
    end

    assign o_ctl = r4_ctl;
    assign o_neg = r4_neg;
    assign o_amag = r4_amag;
    assign o_dmag = r4_dmag;
    assign o_x1 = r4_x1;
    assign o_y1 = r4_y1;
    assign o_x2 = r4_x2;
    assign o_y2 = r4_y2;
    assign o_l = r4_l;
    assign o_t = r4_t;
    assign o_r = r4_r;
    assign o_b = r4_b;

endmodule

/* hdl/srect_div.sv */
// pipelined restoring divider, one quotient bit per stage
module srect_div #(
    parameter int CW = srect_pkg::COORD_BITS_DEF,
    parameter int FW = srect_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [2*CW+FW+2:0]    i_amag,
    input  logic [CW:0]           i_dmag,
    output logic [CW+FW:0]        o_quo,
    output logic                  o_ovf
);
    localparam int AW = 2 * CW + FW + 3;
    localparam int QW = CW + FW + 1;
    localparam int RW = CW + 2;
    localparam int EW = CW + 1;

    logic [RW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic [EW-1:0] r_d   [0:QW];
    logic          r_ovf [0:QW];

    logic [RW-1:0] n_rem0;
    logic [RW:0]   n_trial [1:QW];
    logic          n_ge    [1:QW];
    logic [RW-1:0] n_rem   [1:QW];

    // quotient too wide (or zero divisor) shows as high part >= divisor
    assign n_rem0 = i_amag[AW-1:QW];

    always_comb begin
        for (int s = 1; s <= QW; s++) begin
            n_trial[s] = {r_rem[s-1], r_quo[s-1][QW-1]};
            n_ge[s]    = n_trial[s] >= (RW+1)'(r_d[s-1]);
            n_rem[s]   = n_ge[s] ? RW'(n_trial[s] - (RW+1)'(r_d[s-1])) : RW'(n_trial[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_rem0;
        r_quo[0] <= i_amag[QW-1:0];
        r_d[0]   <= i_dmag;
        r_ovf[0] <= n_rem0 >= RW'(i_dmag);
        for (int s = 1; s <= QW; s++) begin
            r_rem[s] <= n_rem[s];
            r_quo[s] <= {r_quo[s-1][QW-2:0], n_ge[s]};
            r_d[s]   <= r_d[s-1];
            r_ovf[s] <= r_ovf[s-1];
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

/* hdl/srect_check.sv */
// per-edge sign fix, box bounds and hit decision, two stages
module srect_check #(
    parameter int CW = srect_pkg::COORD_BITS_DEF,
    parameter int FW = srect_pkg::FRAC_BITS_DEF,
    parameter int TW = srect_pkg::TOL_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic                   i_ovf,
    input  logic                   i_neg,
    input  logic        [CW+FW:0]  i_qmag,
    input  logic signed [CW-1:0]   i_mv_a,
    input  logic signed [CW-1:0]   i_mv_b,
    input  logic signed [CW:0]     i_lo,
    input  logic signed [CW:0]     i_hi,
    input  logic signed [CW-1:0]   i_fx_a,
    input  logic signed [CW-1:0]   i_fx_b,
    input  logic signed [CW:0]     i_c,
    input  logic        [TW-1:0]   i_tol,
    output logic                   o_hit,
    output logic signed [CW+FW:0]  o_mov,
    output logic signed [CW+FW:0]  o_fix
);
    localparam int QW = CW + FW + 1;
    localparam int XW = CW + FW + 4;

    logic signed [XW-1:0] n_qe, n_tol, n_mmn, n_mmx, n_fmn, n_fmx;
    logic signed [XW-1:0] r_q, r_mlo, r_mhi, r_elo, r_ehi, r_flo, r_fhi, r_cf;
    logic                 r_ok;
    logic                 n_hit;

    always_comb begin
        n_qe  = XW'(i_qmag);
        n_tol = XW'(i_tol);
        n_mmn = (i_mv_a < i_mv_b) ? XW'(i_mv_a) : XW'(i_mv_b);
        n_mmx = (i_mv_a < i_mv_b) ? XW'(i_mv_b) : XW'(i_mv_a);
        n_fmn = (i_fx_a < i_fx_b) ? XW'(i_fx_a) : XW'(i_fx_b);
        n_fmx = (i_fx_a < i_fx_b) ? XW'(i_fx_b) : XW'(i_fx_a);
    end

    always_ff @(posedge i_clk) begin
        r_ok  <= i_en & ~i_ovf;
        r_q   <= i_neg ? -n_qe : n_qe;
        r_mlo <= (n_mmn <<< FW) - n_tol;
        r_mhi <= (n_mmx <<< FW) + n_tol;
        r_elo <= (XW'(i_lo) <<< FW) - n_tol;
        r_ehi <= (XW'(i_hi) <<< FW) + n_tol;
        r_flo <= (n_fmn <<< FW) - n_tol;
        r_fhi <= (n_fmx <<< FW) + n_tol;
        r_cf  <= XW'(i_c) <<< FW;
    end

    assign n_hit = r_ok && (r_q >= r_mlo) && (r_q <= r_mhi) && (r_q >= r_elo)
                   && (r_q <= r_ehi) && (r_cf >= r_flo) && (r_cf <= r_fhi);

    always_ff @(posedge i_clk) begin
        o_hit <= n_hit;
        o_mov <= n_hit ? r_q[QW-1:0] : '0;
        o_fix <= n_hit ? r_cf[QW-1:0] : '0;
    end

endmodule

/* hdl/segment_rectangle_intersect_core.sv */
// top level of the segment against axis-aligned rectangle intersection core
//
// usage: drive the segment endpoints and the rectangle corner/size and pulse
// start; a word is taken at every clock edge with start high and busy low.
// busy never rises, so a new word can enter every cycle.
// each result word shows on the o_* result ports for one cycle with o_done
// high; the receiver has no way to hold it off and must take it then.
// the pipeline has four front stages (edge setup, multipliers, numerators,
// magnitudes), one divider setup stage plus one stage per quotient bit
// (COORD_BITS+FRAC_BITS+1), then two stages of bounds and hit checks.
// throughput is one word per cycle; the four per-edge dividers set the latency.
// the tolerance register is written through i_cfg_valid/i_cfg_data
// (o_cfg_ready is always high) and should only change while no word is in
// flight. reset clears the pipeline valid bits and loads tolerance 3.
module segment_rectangle_intersect_core #(
    parameter int COORD_BITS = srect_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = srect_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_BITS-1:0]         i_seg_start_x,
    input  logic signed [COORD_BITS-1:0]         i_seg_start_y,
    input  logic signed [COORD_BITS-1:0]         i_seg_end_x,
    input  logic signed [COORD_BITS-1:0]         i_seg_end_y,
    input  logic signed [COORD_BITS-1:0]         i_rect_left,
    input  logic signed [COORD_BITS-1:0]         i_rect_top,
    input  logic        [COORD_BITS-2:0]         i_rect_width,
    input  logic        [COORD_BITS-2:0]         i_rect_height,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [srect_pkg::TOL_BITS-1:0] i_cfg_data,
    output logic                                 o_done,
    output logic                                 o_hit_top,
    output logic                                 o_hit_right,
    output logic                                 o_hit_bottom,
    output logic                                 o_hit_left,
    output logic signed [COORD_BITS+FRAC_BITS:0] o_top_point_x,
    output logic signed [COORD_BITS+FRAC_BITS:0] o_top_point_y,
    output logic signed [COORD_BITS+FRAC_BITS:0] o_right_point_x,
    output logic signed [COORD_BITS+FRAC_BITS:0] o_right_point_y,
    output logic signed [COORD_BITS+FRAC_BITS:0] o_bottom_point_x,
    output logic signed [COORD_BITS+FRAC_BITS:0] o_bottom_point_y,
    output logic signed [COORD_BITS+FRAC_BITS:0] o_left_point_x,
    output logic signed [COORD_BITS+FRAC_BITS:0] o_left_point_y
);
    import srect_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int FW = FRAC_BITS;
    localparam int EW = CW + 1;
    localparam int AW = 2 * CW + FW + 3;
    localparam int QW = CW + FW + 1;
    // divider latency, matched by the side delay line
    localparam int DL = QW + 1;
    // scaled tolerance width
    localparam int TW = (FW > TOL_BITS) ? FW : TOL_BITS;

    logic [TOL_BITS-1:0] r_tol;
    logic [TW-1:0]       w_tol;

    // front outputs
    t_ctl                 f_ctl;
    logic                 f_neg  [NUM_EDGES];
    logic [AW-1:0]        f_amag [NUM_EDGES];
    logic [EW-1:0]        f_dmag [NUM_EDGES];
    logic signed [CW-1:0] f_x1, f_y1, f_x2, f_y2;
    logic signed [EW-1:0] f_l, f_t, f_r, f_b;

    // divider outputs
    logic [QW-1:0]        q_mag [NUM_EDGES];
    logic                 q_ovf [NUM_EDGES];

    // side delay line alongside the dividers
    t_ctl                 r_dctl [0:DL-1];
    logic [NUM_EDGES-1:0] r_dneg [0:DL-1];
    logic signed [CW-1:0] r_dx1 [0:DL-1], r_dy1 [0:DL-1], r_dx2 [0:DL-1], r_dy2 [0:DL-1];
    logic signed [EW-1:0] r_dl [0:DL-1], r_dt [0:DL-1], r_dr [0:DL-1], r_db [0:DL-1];

    // check stage valids
    logic r_vld_a;
    logic r_done;

    logic                 w_hit [NUM_EDGES];
    logic signed [QW-1:0] w_mov [NUM_EDGES];
    logic signed [QW-1:0] w_fix [NUM_EDGES];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // rescale from 1/256 units to the output fraction
    generate
        if (FW >= TOL_BITS) begin : g_tol_up
            assign w_tol = TW'(r_tol) << (FW - TOL_BITS);
        end else begin : g_tol_dn
            assign w_tol = TW'(r_tol >> (TOL_BITS - FW));
        end
    endgenerate

    srect_front #(.CW(CW), .FW(FW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_x1    (i_seg_start_x),
        .i_y1    (i_seg_start_y),
        .i_x2    (i_seg_end_x),
        .i_y2    (i_seg_end_y),
        .i_l     (i_rect_left),
        .i_t     (i_rect_top),
        .i_w     (i_rect_width),
        .i_h     (i_rect_height),
        .o_ctl   (f_ctl),
        .o_neg   (f_neg),
        .o_amag  (f_amag),
        .o_dmag  (f_dmag),
        .o_x1    (f_x1),
        .o_y1    (f_y1),
        .o_x2    (f_x2),
        .o_y2    (f_y2),
        .o_l     (f_l),
        .o_t     (f_t),
        .o_r     (f_r),
        .o_b     (f_b)
    );

    // one divider per edge: the moving coordinate of each crossing
    generate
        for (genvar k = 0; k < NUM_EDGES; k++) begin : g_div
            srect_div #(.CW(CW), .FW(FW)) u_div (
                .i_clk  (i_clk),
                .i_amag (f_amag[k]),
                .i_dmag (f_dmag[k]),
                .o_quo  (q_mag[k]),
                .o_ovf  (q_ovf[k])
            );
        end
    endgenerate

    // control part of the side line needs reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DL; s++) begin
                r_dctl[s] <= '0;
            end
            r_vld_a <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_dctl[0] <= f_ctl;
            for (int s = 1; s < DL; s++) begin
                r_dctl[s] <= r_dctl[s-1];
            end
            r_vld_a <= r_dctl[DL-1].vld;
            r_done  <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_EDGES; k++) begin
            r_dneg[0][k] <= f_neg[k];
        end
        r_dx1[0] <= f_x1;
        r_dy1[0] <= f_y1;
        r_dx2[0] <= f_x2;
        r_dy2[0] <= f_y2;
        r_dl[0]  <= f_l;
        r_dt[0]  <= f_t;
        r_dr[0]  <= f_r;
        r_db[0]  <= f_b;
        for (int s = 1; s < DL; s++) begin
            r_dneg[s] <= r_dneg[s-1];
            r_dx1[s]  <= r_dx1[s-1];
            r_dy1[s]  <= r_dy1[s-1];
            r_dx2[s]  <= r_dx2[s-1];
            r_dy2[s]  <= r_dy2[s-1];
            r_dl[s]   <= r_dl[s-1];
            r_dt[s]   <= r_dt[s-1];
            r_dr[s]   <= r_dr[s-1];
            r_db[s]   <= r_db[s-1];
        end
    end

    // top/bottom edges move along x, right/left edges along y
    generate
        for (genvar k = 0; k < NUM_EDGES; k++) begin : g_chk
            if (k == EDGE_TOP || k == EDGE_BOTTOM) begin : g_horiz
                srect_check #(.CW(CW), .FW(FW), .TW(TW)) u_chk (
                    .i_clk  (i_clk),
                    .i_en   (r_dctl[DL-1].wnz),
                    .i_ovf  (q_ovf[k]),
                    .i_neg  (r_dneg[DL-1][k]),
                    .i_qmag (q_mag[k]),
                    .i_mv_a (r_dx1[DL-1]),
                    .i_mv_b (r_dx2[DL-1]),
                    .i_lo   (r_dl[DL-1]),
                    .i_hi   (r_dr[DL-1]),
                    .i_fx_a (r_dy1[DL-1]),
                    .i_fx_b (r_dy2[DL-1]),
                    .i_c    ((k == EDGE_TOP) ? r_dt[DL-1] : r_db[DL-1]),
                    .i_tol  (w_tol),
                    .o_hit  (w_hit[k]),
                    .o_mov  (w_mov[k]),
                    .o_fix  (w_fix[k])
                );
            end else begin : g_vert
                srect_check #(.CW(CW), .FW(FW), .TW(TW)) u_chk (
                    .i_clk  (i_clk),
                    .i_en   (r_dctl[DL-1].hnz),
                    .i_ovf  (q_ovf[k]),
                    .i_neg  (r_dneg[DL-1][k]),
                    .i_qmag (q_mag[k]),
                    .i_mv_a (r_dy1[DL-1]),
                    .i_mv_b (r_dy2[DL-1]),
                    .i_lo   (r_dt[DL-1]),
                    .i_hi   (r_db[DL-1]),
                    .i_fx_a (r_dx1[DL-1]),
                    .i_fx_b (r_dx2[DL-1]),
                    .i_c    ((k == EDGE_RIGHT) ? r_dr[DL-1] : r_dl[DL-1]),
                    .i_tol  (w_tol),
                    .o_hit  (w_hit[k]),
                    .o_mov  (w_mov[k]),
                    .o_fix  (w_fix[k])
                );
            end
        end
    endgenerate

    assign o_done = r_done;

    assign o_hit_top    = w_hit[EDGE_TOP];
    assign o_hit_right  = w_hit[EDGE_RIGHT];
    assign o_hit_bottom = w_hit[EDGE_BOTTOM];
    assign o_hit_left   = w_hit[EDGE_LEFT];

    // horizontal edges: x from the divider, y is the edge line
    assign o_top_point_x    = w_mov[EDGE_TOP];
    assign o_top_point_y    = w_fix[EDGE_TOP];
    assign o_bottom_point_x = w_mov[EDGE_BOTTOM];
    assign o_bottom_point_y = w_fix[EDGE_BOTTOM];
    // vertical edges: x is the edge line, y from the divider
    assign o_right_point_x  = w_fix[EDGE_RIGHT];
    assign o_right_point_y  = w_mov[EDGE_RIGHT];
    assign o_left_point_x   = w_fix[EDGE_LEFT];
    assign o_left_point_y   = w_mov[EDGE_LEFT];

endmodule
